/* rtl/trdp_pkg.sv */
// Shared types, constants and command codes for the touch report descriptor parser.
package trdp_pkg;

  localparam int unsigned DescDepthDef   = 256;
  localparam int unsigned ReportDepthDef = 1024;
  localparam int unsigned SlotCountDef   = 10;

  typedef enum logic [1:0] {
    CMD_LOAD_DESC   = 2'd0,
    CMD_LOAD_REPORT = 2'd1,
    CMD_PARSE       = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_e;

  localparam logic [7:0] CodeEnd        = 8'h00;
  localparam logic [7:0] CodeEachActive = 8'h01;
  localparam logic [7:0] CodeEachObject = 8'h02;
  localparam logic [7:0] CodeEachEnd    = 8'h03;
  localparam logic [7:0] CodePad        = 8'h04;
  localparam logic [7:0] CodeIndex      = 8'h06;
  localparam logic [7:0] CodeClass      = 8'h07;
  localparam logic [7:0] CodeX          = 8'h08;
  localparam logic [7:0] CodeY          = 8'h09;
  localparam logic [7:0] CodeZ          = 8'h0a;
  localparam logic [7:0] CodeActCount   = 8'h18;

  localparam logic [0:0] RegObjectLimit = 1'd0;
  localparam logic [0:0] RegDescLength  = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CODE_RD,
    ST_CODE,
    ST_LEN_RD,
    ST_LEN,
    ST_BIT_RD,
    ST_BIT,
    ST_APPLY,
    ST_SKIP_RD,
    ST_SKIP,
    ST_SKIP_LEN,
    ST_EMIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  position;
    logic [7:0]  byte_value;
    logic [10:0] report_bytes;
  } in_item_t;

  typedef struct packed {
    logic        slot_valid;
    logic [3:0]  slot_number;
    logic        touching;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        last;
  } out_item_t;

endpackage

/* rtl/touch_report_descriptor_parser_core.sv */
// Touch report descriptor parser: byte loads, descriptor walk with bit-serial field reads, slot results.
//
// A load is the transfer, then a write of the byte in which stall stays high.
// A parse walks the descriptor one code at a time through a single registered read port
// on each byte store. A code with a bit field then reads its length byte and fetches the
// field bit by bit from the report store (up to 32 bits kept; a field that runs past the
// report fetches none). A zero active count, or one whose field fails, skips ahead code by
// code and past each skipped length byte. The walk stops after at most 8*DESC_DEPTH codes.
// The results then go out slot by slot over the SLOT_COUNT slots, held while a result is
// stalled. The block takes no item while a command is in progress.
// cfg is always ready and must be written only while the block is idle.
module touch_report_descriptor_parser_core
  import trdp_pkg::*;
#(
  parameter int unsigned DESC_DEPTH   = DescDepthDef,
  parameter int unsigned REPORT_DEPTH = ReportDepthDef,
  parameter int unsigned SLOT_COUNT   = SlotCountDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  localparam int unsigned DAW = $clog2(DESC_DEPTH);
  localparam int unsigned RAW = $clog2(REPORT_DEPTH);
  localparam int unsigned SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned BW  = $clog2(8 * DESC_DEPTH) + 1;
  // bit offset: up to 255 bits per code over the whole step budget, may exceed report bits
  localparam int unsigned OW  = (BW + 8 > RAW + 4) ? BW + 8 : RAW + 4;

  logic [7:0] desc_mem [DESC_DEPTH];
  logic [7:0] rep_mem  [REPORT_DEPTH];
  logic [7:0] desc_rd_q, rep_rd_q;
  logic [DAW-1:0] desc_addr;
  logic [RAW-1:0] rep_addr;
  logic desc_we, rep_we;

  logic [3:0] obj_limit_q;
  logic [8:0] desc_len_q;

  state_e state_q, state_d;
  in_item_t item_q;
  logic load_q;
  logic [10:0] idx_q, idx_d, start_q, start_d;
  logic [OW:0] off_q, off_d;
  logic [31:0] data_q, data_d, active_q, active_d, counted_q, counted_d, obj_q, obj_d;
  logic [7:0] code_q, code_d, bits_q, bits_d, bitn_q, bitn_d;
  logic [BW-1:0] budget_q, budget_d;
  logic have_q, have_d, only_q, only_d, fail_q, fail_d;
  logic [SLOT_COUNT-1:0] seen_q, seen_d;
  logic [7:0]  cls_q [SLOT_COUNT];
  logic [15:0] sx_q  [SLOT_COUNT];
  logic [15:0] sy_q  [SLOT_COUNT];
  logic [7:0]  sz_q  [SLOT_COUNT];
  logic slot_we;
  logic [SW-1:0] slot_i;
  logic [5:0] emit_q, emit_d;
  logic any_q, any_d;
  out_item_t out_q, out_d;
  logic out_v_q, out_v_d;

  logic [9:0]  dlen;
  logic [OW:0] rbits;
  logic [11:0] rbytes_sat;
  logic [OW+1:0] fend;
  logic [OW:0] bitpos;
  logic act;

  assign dlen = (32'(desc_len_q) > DESC_DEPTH) ? 10'(DESC_DEPTH) : {1'b0, desc_len_q};
  assign rbytes_sat = (32'(item_q.report_bytes) > REPORT_DEPTH) ?
                      12'(REPORT_DEPTH) : {1'b0, item_q.report_bytes};
  assign rbits = (OW+1)'({rbytes_sat, 3'b000});
  assign fend = (OW+2)'(off_q) + (OW+2)'(bits_q);
  assign bitpos = off_q + (OW+1)'(bitn_q);

  always_ff @(posedge clk_i) begin
    if (desc_we) desc_mem[desc_addr] <= item_q.byte_value;
    desc_rd_q <= desc_mem[desc_addr];
  end
  always_ff @(posedge clk_i) begin
    if (rep_we) rep_mem[rep_addr] <= item_q.byte_value;
    rep_rd_q <= rep_mem[rep_addr];
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_limit_q <= 4'd10;
      desc_len_q  <= 9'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegObjectLimit) obj_limit_q <= cfg_data_i[3:0];
      else desc_len_q <= cfg_data_i;
    end
  end

  // hold off the next transfer while a command runs or a load writes its byte
  assign in_stall_o  = (state_q != ST_IDLE) || load_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign act = (cls_q[emit_q[SW-1:0]] == 8'd1) || (cls_q[emit_q[SW-1:0]] == 8'd2);

  always_comb begin
    state_d = state_q; idx_d = idx_q; start_d = start_q; off_d = off_q;
    data_d = data_q; active_d = active_q; counted_d = counted_q; obj_d = obj_q;
    code_d = code_q; bits_d = bits_q; bitn_d = bitn_q; budget_d = budget_q;
    have_d = have_q; only_d = only_q; fail_d = fail_q; seen_d = seen_q;
    emit_d = emit_q; any_d = any_q; out_d = out_q; out_v_d = out_v_q;
    desc_we = load_q && (item_q.cmd == CMD_LOAD_DESC) &&
              (32'(item_q.position) < DESC_DEPTH);
    rep_we  = load_q && (item_q.cmd == CMD_LOAD_REPORT) &&
              (32'(item_q.position) < REPORT_DEPTH);
    slot_we = 1'b0;
    desc_addr = load_q ? DAW'(item_q.position) : idx_q[DAW-1:0];
    rep_addr  = load_q ? RAW'(item_q.position) : bitpos[RAW+2:3];
    slot_i    = obj_q[SW-1:0];
    if (out_v_q && !out_stall_i) out_v_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_IDLE;
      end
      ST_CODE_RD: begin
        if (idx_q >= 11'(dlen) || budget_q == '0) begin
          emit_d = '0; any_d = 1'b0; state_d = ST_EMIT;
        end else begin
          budget_d = budget_q - 1'b1; state_d = ST_CODE;
        end
      end
      ST_CODE: begin
        code_d = desc_rd_q;
        idx_d = idx_q + 1'b1;
        state_d = ST_CODE_RD;
        priority case (desc_rd_q)
          CodeEnd: begin emit_d = '0; any_d = 1'b0; state_d = ST_EMIT; end
          CodeEachActive, CodeEachObject: begin
            obj_d = '0; start_d = idx_q + 1'b1; only_d = (desc_rd_q == CodeEachActive);
          end
          CodeEachEnd: begin
            if (off_q < rbits) begin
              obj_d = obj_q + 1'b1;
              if (only_q) begin
                if (have_q) begin
                  counted_d = counted_q + 1'b1;
                  if (counted_q + 1'b1 < active_q) idx_d = start_q;
                end else idx_d = start_q;
              end else if (obj_q + 1'b1 < 32'(obj_limit_q)) idx_d = start_q;
            end
          end
          CodePad: off_d = (off_q + (OW+1)'(7)) & ~(OW+1)'(7);
          default: state_d = ST_LEN_RD;
        endcase
      end
      ST_LEN_RD: state_d = ST_LEN;
      ST_LEN: begin
        bits_d = (idx_q < 11'(dlen)) ? desc_rd_q : 8'd0;
        idx_d = idx_q + 1'b1;
        data_d = '0; bitn_d = '0;
        state_d = ST_BIT_RD;
      end
      ST_BIT_RD: begin
        fail_d = (fend > (OW+2)'(rbits));
        if (fend > (OW+2)'(rbits) || bitn_q == bits_q || bitn_q == 8'd32) begin
          state_d = ST_APPLY;
        end else state_d = ST_BIT;
      end
      ST_BIT: begin
        data_d = data_q | (32'(rep_rd_q[bitpos[2:0]]) << bitn_q[4:0]);
        bitn_d = bitn_q + 1'b1;
        state_d = ST_BIT_RD;
      end
      ST_APPLY: begin
        state_d = ST_CODE_RD;
        off_d = (OW+1)'(fend);
        if (fail_q) data_d = '0;
        priority case (code_q)
          CodeActCount: begin
            active_d = fail_q ? '0 : data_q; have_d = 1'b1;
            if (fail_q || data_q == '0) state_d = ST_SKIP_RD;
          end
          CodeIndex: obj_d = fail_q ? '0 : data_q;
          CodeClass, CodeX, CodeY, CodeZ: begin
            if (obj_q < 32'(SLOT_COUNT)) begin
              slot_we = 1'b1;
              if (code_q == CodeClass) seen_d[slot_i] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_SKIP_RD: state_d = (idx_q < 11'(dlen)) ? ST_SKIP : ST_CODE_RD;
      ST_SKIP: begin
        idx_d = idx_q + 1'b1;
        if (desc_rd_q == CodeEachEnd) state_d = ST_CODE_RD;
        else if (desc_rd_q == CodeEnd) begin idx_d = idx_q; state_d = ST_CODE_RD; end
        else if (desc_rd_q == CodeEachActive || desc_rd_q == CodeEachObject ||
                 desc_rd_q == CodePad) state_d = ST_SKIP_RD;
        else state_d = ST_SKIP_LEN;
      end
      ST_SKIP_LEN: begin
        idx_d = idx_q + 1'b1; state_d = ST_SKIP_RD;
      end
      ST_EMIT: begin
        if (!out_v_q || !out_stall_i) begin
          if (emit_q == 6'(SLOT_COUNT)) begin
            if (!any_q) begin
              out_d = '0; out_d.last = 1'b1; out_v_d = 1'b1;
            end
            state_d = ST_IDLE;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        emit_d = emit_q + 1'b1;
        state_d = ST_EMIT;
        if (seen_q[emit_q[SW-1:0]]) begin
          out_d.slot_valid = 1'b1;
          out_d.slot_number = 4'(emit_q);
          out_d.touching = act;
          out_d.pos_x = act ? sx_q[emit_q[SW-1:0]] : 16'd0;
          out_d.pos_y = act ? sy_q[emit_q[SW-1:0]] : 16'd0;
          out_d.last = ((seen_q >> (emit_q + 1'b1)) == '0);
          out_v_d = 1'b1;
          any_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_IDLE && in_valid_i) begin
      state_d = ST_IDLE;
    end
  end

  // Command launch and loads handled in their own register path.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; out_v_q <= 1'b0; seen_q <= '0; load_q <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cls_q[i] <= '0; sx_q[i] <= '0; sy_q[i] <= '0; sz_q[i] <= '0;
      end
    end else begin
      load_q  <= 1'b0;
      out_v_q <= out_v_d;
      if (state_q == ST_IDLE) begin
        if (in_valid_i && !load_q) begin
          if (in_data_i.cmd == CMD_PARSE) begin
            state_q <= ST_CODE_RD; seen_q <= '0;
          end else load_q <= 1'b1;
        end
      end else begin
        state_q <= state_d;
        seen_q  <= seen_d;
      end
      if (slot_we) begin
        priority case (code_q)
          CodeClass: cls_q[slot_i] <= data_d[7:0];
          CodeX:     sx_q[slot_i]  <= data_d[15:0];
          CodeY:     sy_q[slot_i]  <= data_d[15:0];
          default:   sz_q[slot_i]  <= data_d[7:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && !load_q) begin
      item_q <= in_data_i;
      idx_q <= '0; off_q <= '0; start_q <= '0; active_q <= '0; counted_q <= '0;
      obj_q <= '0; have_q <= 1'b0; only_q <= 1'b0; fail_q <= 1'b0;
      budget_q <= BW'(8 * DESC_DEPTH);
      code_q <= '0; bits_q <= '0; bitn_q <= '0; data_q <= '0; emit_q <= '0; any_q <= 1'b0;
    end else begin
      idx_q <= idx_d; start_q <= start_d; off_q <= off_d; data_q <= data_d;
      active_q <= active_d; counted_q <= counted_d; obj_q <= obj_d; code_q <= code_d;
      bits_q <= bits_d; bitn_q <= bitn_d; budget_q <= budget_d; have_q <= have_d;
      only_q <= only_d; fail_q <= fail_d; emit_q <= emit_d; any_q <= any_d;
    end
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CODE) |-> (budget_q < BW'(8 * DESC_DEPTH))) else $error("budget");
`endif

endmodule
